// ===== rtl/rbae_pkg.sv =====
// ----------------------------------------------------------------------------
// rbae_pkg
// Shared types and fixed constants for the rotated box extents pipeline.
// ----------------------------------------------------------------------------
package rbae_pkg;

   // Quaternion components are signed with a fixed width.
   localparam int QUAT_W   = 16;
   // Full width of a component product.
   localparam int PROD_W   = 2 * QUAT_W;
   // Number of axes (matrix rows and columns).
   localparam int NUM_AXES = 3;

   typedef logic signed [QUAT_W-1:0] quat_comp_type;

   typedef struct packed {
      quat_comp_type w;
      quat_comp_type z;
      quat_comp_type y;
      quat_comp_type x;
   } quat_type;

endpackage

// ===== rtl/rbae_quat_mat.sv =====
// ----------------------------------------------------------------------------
// rbae_quat_mat
// Two pipeline stages: quaternion component products, then the absolute
// values of the nine rotation matrix entries. Half sizes and the rotation
// flag travel alongside.
// ----------------------------------------------------------------------------
module rbae_quat_mat #(
   parameter int  QUAT_FRAC_BITS = 14,
   parameter int  SIZE_WIDTH     = 24,
   localparam int SH_W = rbae_pkg::PROD_W - QUAT_FRAC_BITS,
   localparam int ME_W = (((34 - QUAT_FRAC_BITS) > (QUAT_FRAC_BITS + 2)) ?
                          (34 - QUAT_FRAC_BITS) : (QUAT_FRAC_BITS + 2)) + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  in_rot,
   input  logic [2:0][SIZE_WIDTH-1:0]            in_half,
   input  rbae_pkg::quat_type                    in_quat,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic                                  out_rot,
   output logic [2:0][SIZE_WIDTH-1:0]            out_half,
   output logic [2:0][2:0][ME_W-1:0]             out_mag
);

   localparam logic signed [ME_W-1:0] ONE = ME_W'(1) << QUAT_FRAC_BITS;

   function automatic logic signed [ME_W-1:0] sext(input logic [SH_W-1:0] v);
      return ME_W'($signed(v));
   endfunction

   function automatic logic [ME_W-1:0] absv(input logic signed [ME_W-1:0] v);
      return v[ME_W-1] ? ME_W'(-v) : ME_W'(v);
   endfunction

   logic en1, en2;

   // stage 1 registers
   logic                       v1_ff;
   logic                       rot1_ff;
   logic [2:0][SIZE_WIDTH-1:0] half1_ff;
   logic [SH_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic [SH_W-1:0] xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;

   // stage 2 registers
   logic                       v2_ff;
   logic                       rot2_ff;
   logic [2:0][SIZE_WIDTH-1:0] half2_ff;
   logic [2:0][2:0][ME_W-1:0]  mag_ff;
   logic [2:0][2:0][ME_W-1:0]  mag_in;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Exact products, floored to QUAT_FRAC_BITS fraction bits.
   always_comb begin
      logic signed [rbae_pkg::PROD_W-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
      logic signed [rbae_pkg::PROD_W-1:0] p_wx, p_wy, p_wz;
      p_xx  = $signed(in_quat.x) * $signed(in_quat.x);
      p_yy  = $signed(in_quat.y) * $signed(in_quat.y);
      p_zz  = $signed(in_quat.z) * $signed(in_quat.z);
      p_xy  = $signed(in_quat.x) * $signed(in_quat.y);
      p_xz  = $signed(in_quat.x) * $signed(in_quat.z);
      p_yz  = $signed(in_quat.y) * $signed(in_quat.z);
      p_wx  = $signed(in_quat.w) * $signed(in_quat.x);
      p_wy  = $signed(in_quat.w) * $signed(in_quat.y);
      p_wz  = $signed(in_quat.w) * $signed(in_quat.z);
      xx_in = SH_W'(p_xx >>> QUAT_FRAC_BITS);
      yy_in = SH_W'(p_yy >>> QUAT_FRAC_BITS);
      zz_in = SH_W'(p_zz >>> QUAT_FRAC_BITS);
      xy_in = SH_W'(p_xy >>> QUAT_FRAC_BITS);
      xz_in = SH_W'(p_xz >>> QUAT_FRAC_BITS);
      yz_in = SH_W'(p_yz >>> QUAT_FRAC_BITS);
      wx_in = SH_W'(p_wx >>> QUAT_FRAC_BITS);
      wy_in = SH_W'(p_wy >>> QUAT_FRAC_BITS);
      wz_in = SH_W'(p_wz >>> QUAT_FRAC_BITS);
   end

   // Matrix entries from the floored products, then magnitudes.
   always_comb begin
      logic signed [ME_W-1:0] s_yz2, s_xz2, s_xy2;
      logic signed [ME_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
      s_yz2 = sext(yy_ff) + sext(zz_ff);
      s_xz2 = sext(xx_ff) + sext(zz_ff);
      s_xy2 = sext(xx_ff) + sext(yy_ff);
      e00   = ONE - (s_yz2 <<< 1);
      e01   = (sext(xy_ff) - sext(wz_ff)) <<< 1;
      e02   = (sext(xz_ff) + sext(wy_ff)) <<< 1;
      e10   = (sext(xy_ff) + sext(wz_ff)) <<< 1;
      e11   = ONE - (s_xz2 <<< 1);
      e12   = (sext(yz_ff) - sext(wx_ff)) <<< 1;
      e20   = (sext(xz_ff) - sext(wy_ff)) <<< 1;
      e21   = (sext(yz_ff) + sext(wx_ff)) <<< 1;
      e22   = ONE - (s_xy2 <<< 1);
      mag_in[0][0] = absv(e00);
      mag_in[0][1] = absv(e01);
      mag_in[0][2] = absv(e02);
      mag_in[1][0] = absv(e10);
      mag_in[1][1] = absv(e11);
      mag_in[1][2] = absv(e12);
      mag_in[2][0] = absv(e20);
      mag_in[2][1] = absv(e21);
      mag_in[2][2] = absv(e22);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         rot1_ff  <= in_rot;
         half1_ff <= in_half;
         xx_ff    <= xx_in;
         yy_ff    <= yy_in;
         zz_ff    <= zz_in;
         xy_ff    <= xy_in;
         xz_ff    <= xz_in;
         yz_ff    <= yz_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         wz_ff    <= wz_in;
      end
      if (en2) begin
         rot2_ff  <= rot1_ff;
         half2_ff <= half1_ff;
         mag_ff   <= mag_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_rot   = rot2_ff;
   assign out_half  = half2_ff;
   assign out_mag   = mag_ff;

endmodule

// ===== rtl/rbae_row_scale.sv =====
// ----------------------------------------------------------------------------
// rbae_row_scale
// Two pipeline stages: half size times entry magnitude for all nine
// entries, then per-row sum, scale down and saturate, or pass the half
// size if unrotated. The second stage register is the output register.
// ----------------------------------------------------------------------------
module rbae_row_scale #(
   parameter int  QUAT_FRAC_BITS = 14,
   parameter int  SIZE_WIDTH     = 24,
   parameter int  ME_W           = 21,
   localparam int EXT_W = SIZE_WIDTH + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_rot,
   input  logic [2:0][SIZE_WIDTH-1:0]      in_half,
   input  logic [2:0][2:0][ME_W-1:0]       in_mag,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [2:0][EXT_W-1:0]           out_ext
);

   localparam int PRD_W = SIZE_WIDTH + ME_W;
   localparam int SUM_W = PRD_W + 2;

   logic en3, en4;

   logic                       v3_ff;
   logic                       rot3_ff;
   logic [2:0][SIZE_WIDTH-1:0] half3_ff;
   logic [2:0][2:0][PRD_W-1:0] prd_ff;
   logic [2:0][2:0][PRD_W-1:0] prd_in;

   logic                       v4_ff;
   logic [2:0][EXT_W-1:0]      ext_ff;
   logic [2:0][EXT_W-1:0]      ext_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   always_comb begin
      for (int r = 0; r < rbae_pkg::NUM_AXES; r++) begin
         for (int c = 0; c < rbae_pkg::NUM_AXES; c++) begin
            prd_in[r][c] = PRD_W'(in_half[c]) * PRD_W'(in_mag[r][c]);
         end
      end
   end

   // Rotated: sum rows, drop fraction bits, clamp; else pass half sizes.
   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] scaled;
      for (int r = 0; r < rbae_pkg::NUM_AXES; r++) begin
         sum    = SUM_W'(prd_ff[r][0]) + SUM_W'(prd_ff[r][1]) + SUM_W'(prd_ff[r][2]);
         scaled = sum >> QUAT_FRAC_BITS;
         if (!rot3_ff) begin
            ext_in[r] = EXT_W'(half3_ff[r]);
         end else if (|scaled[SUM_W-1:EXT_W]) begin
            ext_in[r] = '1;
         end else begin
            ext_in[r] = scaled[EXT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en3) begin
            v3_ff <= in_valid;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rot3_ff  <= in_rot;
         half3_ff <= in_half;
         prd_ff   <= prd_in;
      end
      if (en4) begin
         ext_ff <= ext_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_ext   = ext_ff;

endmodule

// ===== rtl/rotated_box_aabb_extents_core.sv =====
// ----------------------------------------------------------------------------
// rotated_box_aabb_extents_core
// An accepted input word is registered in stage 1, then in 2, 3 and 4;
// rsp_tvalid rises when it reaches the stage 4 register.
// Throughput: one word per cycle when not stalled; each stage holds one box.
// The item rate is set by the four register stages, each with its own valid
// bit; a stalled result holds the whole pipe without loss or repeat.
// Reset (synchronous, active high) clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
// Computes the half extents of the axis aligned box around an oriented box.
// Stage 1: nine quaternion products, floored to the fraction width.
// Stage 2: rotation matrix entries and their magnitudes.
// Stage 3: half size times magnitude, nine multipliers.
// Stage 4: row sums, scale down, saturate; this is the output register.
// With the rotation flag clear, the half sizes pass through unchanged.
// ----------------------------------------------------------------------------
module rotated_box_aabb_extents_core #(
   parameter int  QUAT_FRAC_BITS = 14,
   parameter int  SIZE_WIDTH     = 24,
   localparam int EXT_W  = SIZE_WIDTH + 1,
   localparam int REQ_W  = ((3 * SIZE_WIDTH + 4 * rbae_pkg::QUAT_W + 7) / 8) * 8,
   localparam int RSP_W  = ((3 * EXT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // req_tdata: half_x, half_y, half_z, quat_x, quat_y, quat_z, quat_w, any pad (ignored)
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // req_tuser: rotated
   input  logic             req_tuser,
   // rsp_tdata: ext_x, ext_y, ext_z, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int QOFS = 3 * SIZE_WIDTH;
   localparam int QW   = rbae_pkg::QUAT_W;
   localparam int ME_W = (((34 - QUAT_FRAC_BITS) > (QUAT_FRAC_BITS + 2)) ?
                          (34 - QUAT_FRAC_BITS) : (QUAT_FRAC_BITS + 2)) + 1;

   logic [2:0][SIZE_WIDTH-1:0] req_half;
   rbae_pkg::quat_type         req_quat;

   // Link between the two halves of the pipe.
   logic                       mat_valid;
   logic                       mat_ready;
   logic                       mat_rot;
   logic [2:0][SIZE_WIDTH-1:0] mat_half;
   logic [2:0][2:0][ME_W-1:0]  mat_mag;

   logic [2:0][EXT_W-1:0]      rsp_ext;

   // Unpack the input word: three half sizes, then the quaternion.
   assign req_half[0] = req_tdata[0*SIZE_WIDTH +: SIZE_WIDTH];
   assign req_half[1] = req_tdata[1*SIZE_WIDTH +: SIZE_WIDTH];
   assign req_half[2] = req_tdata[2*SIZE_WIDTH +: SIZE_WIDTH];
   assign req_quat.x  = req_tdata[QOFS + 0*QW +: QW];
   assign req_quat.y  = req_tdata[QOFS + 1*QW +: QW];
   assign req_quat.z  = req_tdata[QOFS + 2*QW +: QW];
   assign req_quat.w  = req_tdata[QOFS + 3*QW +: QW];

   // Products and matrix magnitudes.
   rbae_quat_mat #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
      .SIZE_WIDTH     (SIZE_WIDTH)
   ) u_quat_mat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_rot    (req_tuser),
      .in_half   (req_half),
      .in_quat   (req_quat),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_rot   (mat_rot),
      .out_half  (mat_half),
      .out_mag   (mat_mag)
   );

   // Weighted row sums and saturation.
   rbae_row_scale #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
      .SIZE_WIDTH     (SIZE_WIDTH),
      .ME_W           (ME_W)
   ) u_row_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_rot    (mat_rot),
      .in_half   (mat_half),
      .in_mag    (mat_mag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ext   (rsp_ext)
   );

   // Pack the result word, ext_x in the lowest bits; pad with zeros.
   assign rsp_tdata = RSP_W'(rsp_ext);

endmodule

// ===== sim/extent_check_pkg.sv =====
// ----------------------------------------------------------------------------
// extent_check_pkg
// Box item types, expected-extent calculation and the result scoreboard used
// by the testbench of the rotated box extents core.
// ----------------------------------------------------------------------------
package extent_check_pkg;

   localparam int HALF_W    = 24;
   localparam int EXT_W     = HALF_W + 1;
   localparam int FRAC_BITS = 14;
   localparam int REQ_BITS  = ((3 * HALF_W + 4 * rbae_pkg::QUAT_W + 7) / 8) * 8;
   localparam int RSP_BITS  = ((3 * EXT_W + 7) / 8) * 8;

   localparam longint EXT_MAX = (longint'(1) << EXT_W) - 1;

   typedef logic [HALF_W-1:0] half_type;
   typedef logic [EXT_W-1:0]  ext_type;

   typedef struct packed {
      logic               rotated;
      half_type           half_x;
      half_type           half_y;
      half_type           half_z;
      rbae_pkg::quat_type quat;
   } box_type;

   typedef struct packed {
      ext_type ext_x;
      ext_type ext_y;
      ext_type ext_z;
   } extents_type;

   class extent_scoreboard;
      extents_type expected_q[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      // Product of two components, floored back to the fraction width.
      function longint floor_product(rbae_pkg::quat_comp_type a,
                                     rbae_pkg::quat_comp_type b);
         longint p;
         p = longint'(a) * longint'(b);
         return p >>> FRAC_BITS;
      endfunction

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function ext_type row_extent(box_type b, longint e0, longint e1, longint e2);
         longint sum;
         sum = longint'(b.half_x) * magnitude(e0) + longint'(b.half_y) * magnitude(e1)
             + longint'(b.half_z) * magnitude(e2);
         sum = sum >>> FRAC_BITS;
         if (sum > EXT_MAX) begin
            return '1;
         end
         return ext_type'(sum);
      endfunction

      function extents_type predict_extents(box_type b);
         extents_type r;
         longint      xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
         if (!b.rotated) begin
            r.ext_x = ext_type'(b.half_x);
            r.ext_y = ext_type'(b.half_y);
            r.ext_z = ext_type'(b.half_z);
            return r;
         end
         one = longint'(1) << FRAC_BITS;
         xx  = floor_product(b.quat.x, b.quat.x);
         yy  = floor_product(b.quat.y, b.quat.y);
         zz  = floor_product(b.quat.z, b.quat.z);
         xy  = floor_product(b.quat.x, b.quat.y);
         xz  = floor_product(b.quat.x, b.quat.z);
         yz  = floor_product(b.quat.y, b.quat.z);
         wx  = floor_product(b.quat.w, b.quat.x);
         wy  = floor_product(b.quat.w, b.quat.y);
         wz  = floor_product(b.quat.w, b.quat.z);
         r.ext_x = row_extent(b, one - 2 * (yy + zz), 2 * (xy - wz), 2 * (xz + wy));
         r.ext_y = row_extent(b, 2 * (xy + wz), one - 2 * (xx + zz), 2 * (yz - wx));
         r.ext_z = row_extent(b, 2 * (xz - wy), 2 * (yz + wx), one - 2 * (xx + yy));
         return r;
      endfunction

      function void note_box(box_type b);
         expected_q.push_back(predict_extents(b));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void compare_field(string name, ext_type want, ext_type got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_extents(logic [RSP_BITS-1:0] word);
         extents_type got;
         extents_type want;
         got.ext_x = word[EXT_W-1:0];
         got.ext_y = word[2*EXT_W-1:EXT_W];
         got.ext_z = word[3*EXT_W-1:2*EXT_W];
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word: expected none, actual %h", $time, word);
            return;
         end
         want = expected_q.pop_front();
         compare_field("ext_x", want.ext_x, got.ext_x);
         compare_field("ext_y", want.ext_y, got.ext_y);
         compare_field("ext_z", want.ext_z, got.ext_z);
      endfunction
   endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for rotated_box_aabb_extents_core: directed boxes, then
// random boxes under several idle and stall mixes, every result word checked
// in order against the expected extents.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted word before the run is declared hung.
   localparam int QUIET_LIMIT = 2000;
   // Cycles to keep watching the result port once nothing is expected.
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_ITEMS = 240;
   localparam extent_check_pkg::half_type HALF_MAX = '1;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   // half_x, half_y, half_z, quat_x..quat_w
   logic [extent_check_pkg::REQ_BITS-1:0] req_tdata;
   logic                                  req_tuser;   // rotated
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   // ext_x, ext_y, ext_z, pad
   logic [extent_check_pkg::RSP_BITS-1:0] rsp_tdata;

   // Percent of cycles in which the sender idles / the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;

   extent_check_pkg::extent_scoreboard sb;

   rotated_box_aabb_extents_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Box construction
   // ------------------------------------------------------------------
   function automatic extent_check_pkg::box_type make_box(logic rot,
                                                          extent_check_pkg::half_type hx,
                                                          extent_check_pkg::half_type hy,
                                                          extent_check_pkg::half_type hz,
                                                          int qx, int qy, int qz, int qw);
      extent_check_pkg::box_type b;
      b.rotated = rot;
      b.half_x  = hx;
      b.half_y  = hy;
      b.half_z  = hz;
      b.quat.x  = rbae_pkg::quat_comp_type'(qx);
      b.quat.y  = rbae_pkg::quat_comp_type'(qy);
      b.quat.z  = rbae_pkg::quat_comp_type'(qz);
      b.quat.w  = rbae_pkg::quat_comp_type'(qw);
      return b;
   endfunction

   // Half sizes: mostly small or full range, with a share of edge values.
   function automatic extent_check_pkg::half_type random_half();
      case ($urandom_range(19))
         0:            return '0;
         1:            return HALF_MAX;
         2:            return extent_check_pkg::half_type'(1);
         3, 4, 5:      return extent_check_pkg::half_type'($urandom) | 24'hF00000;
         6, 7, 8, 9:   return extent_check_pkg::half_type'($urandom_range(4095));
         10, 11:       return extent_check_pkg::half_type'($urandom_range(255));
         default:      return extent_check_pkg::half_type'($urandom);
      endcase
   endfunction

   function automatic rbae_pkg::quat_comp_type edge_comp();
      case ($urandom_range(6))
         0:       return rbae_pkg::quat_comp_type'(-32768);
         1:       return rbae_pkg::quat_comp_type'(32767);
         2:       return rbae_pkg::quat_comp_type'(-1);
         3:       return rbae_pkg::quat_comp_type'(1);
         4:       return rbae_pkg::quat_comp_type'(16384);
         5:       return rbae_pkg::quat_comp_type'(-16384);
         default: return '0;
      endcase
   endfunction

   // Mostly unit quaternions, which a real broadphase delivers, plus raw
   // full-range and edge components to hit the unnormalized paths.
   function automatic rbae_pkg::quat_type random_quat();
      rbae_pkg::quat_type q;
      real                c [4];
      real                norm;
      int                 k;
      case ($urandom_range(9))
         0: begin
            q.x = edge_comp();
            q.y = edge_comp();
            q.z = edge_comp();
            q.w = edge_comp();
         end
         1, 2, 3: begin
            q = rbae_pkg::quat_type'({$urandom, $urandom});
         end
         default: begin
            norm = 0.0;
            for (k = 0; k < 4; k++) begin
               c[k] = real'(int'($urandom_range(65535)) - 32768) / 32768.0;
               norm += c[k] * c[k];
            end
            norm = $sqrt(norm);
            if (norm < 0.01) begin
               q   = '0;
               q.w = rbae_pkg::quat_comp_type'(16384);
            end else begin
               q.x = rbae_pkg::quat_comp_type'($rtoi(c[0] / norm * 16384.0));
               q.y = rbae_pkg::quat_comp_type'($rtoi(c[1] / norm * 16384.0));
               q.z = rbae_pkg::quat_comp_type'($rtoi(c[2] / norm * 16384.0));
               q.w = rbae_pkg::quat_comp_type'($rtoi(c[3] / norm * 16384.0));
            end
         end
      endcase
      return q;
   endfunction

   function automatic extent_check_pkg::box_type random_box();
      extent_check_pkg::box_type b;
      b.rotated = ($urandom_range(3) != 0);
      b.half_x  = random_half();
      b.half_y  = random_half();
      b.half_z  = random_half();
      b.quat    = random_quat();
      return b;
   endfunction

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   // Idle at random, then hold the word until the core takes it.
   task automatic send_box(extent_check_pkg::box_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.rotated;
      req_tdata  <= {b.quat, b.half_z, b.half_y, b.half_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_box(b);
   endtask

   // Drop valid and hold off until every expected word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_directed();
      // axis aligned: quaternion fields must be ignored
      send_box(make_box(1'b0, '0, '0, '0, 0, 0, 0, 0));
      send_box(make_box(1'b0, HALF_MAX, HALF_MAX, HALF_MAX, -32768, 32767, -1, 1));
      send_box(make_box(1'b0, 24'h000001, 24'h800000, 24'h555555, 32767, 32767, 32767, 32767));
      // identity and zero quaternion both leave the half sizes unchanged
      send_box(make_box(1'b1, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0, 0, 16384));
      send_box(make_box(1'b1, HALF_MAX, 24'h000001, 24'h123456, 0, 0, 0, 0));
      // quarter turns about z and x, half turns about each axis, a turn about the diagonal
      send_box(make_box(1'b1, 24'h000100, 24'h000200, 24'h000300, 0, 0, 11585, 11585));
      send_box(make_box(1'b1, 24'h000100, 24'h000200, 24'h000300, 11585, 0, 0, -11585));
      send_box(make_box(1'b1, 24'h0ABCDE, 24'h012345, 24'h00FFFF, 16384, 0, 0, 0));
      send_box(make_box(1'b1, 24'h0ABCDE, 24'h012345, 24'h00FFFF, 0, 16384, 0, 0));
      send_box(make_box(1'b1, 24'h0ABCDE, 24'h012345, 24'h00FFFF, 0, 0, 16384, 0));
      send_box(make_box(1'b1, 24'h001000, 24'h002000, 24'h004000, 8192, 8192, 8192, 8192));
      // unnormalized, far above unit length: several drive the extents to saturate
      send_box(make_box(1'b1, HALF_MAX, HALF_MAX, HALF_MAX, 32767, 32767, 32767, 32767));
      send_box(make_box(1'b1, HALF_MAX, HALF_MAX, HALF_MAX, -32768, -32768, -32768, -32768));
      send_box(make_box(1'b1, HALF_MAX, '0, '0, 32767, 0, 0, 0));
      send_box(make_box(1'b1, '0, '0, HALF_MAX, 0, 0, 0, -32768));
      send_box(make_box(1'b1, HALF_MAX, HALF_MAX, HALF_MAX, 23170, 0, 0, 23170));
      send_box(make_box(1'b1, HALF_MAX, HALF_MAX, HALF_MAX, -32768, 32767, -32768, 32767));
      // zero sizes under an extreme rotation
      send_box(make_box(1'b1, '0, '0, '0, -32768, 32767, -32768, 32767));
      // tiny products: positive ones floor to zero, negative ones to minus one
      send_box(make_box(1'b1, 24'hAAAAAA, 24'h555555, HALF_MAX, -1, -1, -1, -1));
      send_box(make_box(1'b1, 24'h000001, 24'h000001, 24'h000001, 1, -1, 1, -1));
   endtask

   // ------------------------------------------------------------------
   // Receiver: check each accepted word, then pick the next ready level.
   // ------------------------------------------------------------------
   initial begin : result_sink
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            sb.check_extents(rsp_tdata);
         end
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if no word moves on either side for too long.
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int p;
      int i;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      // hold the sender until the pipe is empty once
      drain_results();

      // phases: free running, sender idles, receiver stalls, both, free again
      for (p = 0; p < 5; p++) begin
         case (p)
            1:       begin idle_pct = 65; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 65; end
            3:       begin idle_pct = 19; stall_pct = 19; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_box(random_box());
         end
         drain_results();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
